### src/sslt_pkg.sv
`default_nettype none
package sslt_pkg;

	// Width of the reported key count.
	localparam int COUNT_BITS = 5;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_PRESENT = 2'd1,
		STATUS_ABSENT  = 2'd2,
		STATUS_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      descending;
	} cell_ctrl_t;

endpackage
`default_nettype wire

### src/sslt_cell.sv
`default_nettype none
// One slot of the ordered key row. Prefix flags ripple from the head one cell per cycle.
module sslt_cell #(
	parameter int KEY_BITS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire sslt_pkg::cell_ctrl_t       ctrl,
	input  wire logic signed [KEY_BITS-1:0] key_in,
	input  wire logic signed [KEY_BITS-1:0] prev_key,
	input  wire logic                       prev_valid,
	input  wire logic                       prev_hit,
	input  wire logic                       prev_pass,
	input  wire logic signed [KEY_BITS-1:0] next_key,
	input  wire logic                       next_valid,
	output logic signed [KEY_BITS-1:0]      cell_key,
	output logic                            cell_valid,
	output logic                            cell_hit,
	output logic                            cell_pass
);

	logic signed [KEY_BITS-1:0] key_q;
	logic                       valid_q;
	logic                       hit_q;
	logic                       pass_q;
	logic                       eq;
	logic                       keep;

	assign eq   = valid_q && (key_q == key_in);
	assign keep = valid_q && (ctrl.descending ? (key_q >= key_in) : (key_q <= key_in));

	// hit: this cell or one nearer the head holds the key.
	// pass: every cell up to here may stand before the key.
	always_ff @(posedge clk) begin
		hit_q  <= prev_hit | eq;
		pass_q <= prev_pass & keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.cmd)
				sslt_pkg::CMD_INSERT: begin
					if (!pass_q) begin
						valid_q <= prev_pass ? 1'b1 : prev_valid;
					end
				end
				sslt_pkg::CMD_REMOVE: begin
					if (hit_q) begin
						valid_q <= next_valid;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			sslt_pkg::CMD_INSERT: begin
				if (!pass_q) begin
					key_q <= prev_pass ? key_in : prev_key;
				end
			end
			sslt_pkg::CMD_REMOVE: begin
				if (hit_q) begin
					key_q <= next_key;
				end
			end
			default: ;
		endcase
	end

	assign cell_key   = key_q;
	assign cell_valid = valid_q;
	assign cell_hit   = hit_q;
	assign cell_pass  = pass_q;

endmodule
`default_nettype wire

### src/sorted_set_linked_table_top.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// ------    ---------  ---------------------  -------------------------------
// input     in         in_valid / in_ready    opcode[1:0], key[KEY_BITS-1:0]
// result    out        out_valid / out_ready  success, status[1:0], count[4:0]
// config    in         cfg_we (no wait)       cfg_data (order_descending)
//
// Each item is handled in steps: capture of the transfer, a scan while the
// hit/pass flags ripple down the row of cells, then a commit of the shift.
// Reset empties the row at once (valid bits clear); there is no clearing pass.
// A new item is taken as soon as the block is idle, even while a result waits.
// A stalled result holds the commit step until the output slot is free.
module sorted_set_linked_table_top #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 opcode,
	input  wire logic signed [KEY_BITS-1:0] key,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            success,
	output logic [1:0]                      status,
	output logic [sslt_pkg::COUNT_BITS-1:0] count
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int OUT_W = sslt_pkg::COUNT_BITS;

	sslt_pkg::state_t state_q, state_d;

	logic                       order_q;
	logic [1:0]                 op_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [IDX_W-1:0]           cyc_q;
	logic [CNT_W-1:0]           count_q, count_d;
	logic                       out_valid_q, out_valid_d;
	logic                       success_q, success_d;
	logic [1:0]                 status_q, status_d;
	logic                       commit;
	logic                       found;
	logic                       full;
	sslt_pkg::cell_ctrl_t       ctrl;

	logic signed [KEY_BITS-1:0] ck [CAPACITY];
	logic [CAPACITY-1:0]        cv;
	logic [CAPACITY-1:0]        chit;
	logic [CAPACITY-1:0]        cpass;

	// Cell row: slot 0 is the list head; valid cells stay packed toward the head.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [KEY_BITS-1:0] pk, nk;
		logic                       pv, ph, pp, nv;
		if (i == 0) begin : g_head
			assign pk = '0;
			assign pv = 1'b0;
			assign ph = 1'b0;
			assign pp = 1'b1;
		end else begin : g_mid
			assign pk = ck[i-1];
			assign pv = cv[i-1];
			assign ph = chit[i-1];
			assign pp = cpass[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign nk = '0;
			assign nv = 1'b0;
		end else begin : g_body
			assign nk = ck[i+1];
			assign nv = cv[i+1];
		end
		sslt_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.key_in    (key_q),
			.prev_key  (pk),
			.prev_valid(pv),
			.prev_hit  (ph),
			.prev_pass (pp),
			.next_key  (nk),
			.next_valid(nv),
			.cell_key  (ck[i]),
			.cell_valid(cv[i]),
			.cell_hit  (chit[i]),
			.cell_pass (cpass[i])
		);
	end

	// The tail cell's hit flag has seen the whole row once the scan is over.
	assign found = chit[CAPACITY-1];
	assign full  = (count_q == CNT_W'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sslt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		commit      = 1'b0;
		ctrl.cmd    = sslt_pkg::CMD_HOLD;
		ctrl.descending = order_q;
		count_d     = count_q;
		success_d   = success_q;
		status_d    = status_q;
		out_valid_d = out_valid_q && !out_ready;
		unique case (state_q)
			sslt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = sslt_pkg::ST_SCAN;
				end
			end
			sslt_pkg::ST_SCAN: begin
				if (cyc_q == IDX_W'(CAPACITY - 1)) begin
					state_d = sslt_pkg::ST_APPLY;
				end
			end
			sslt_pkg::ST_APPLY: begin
				// Hold here until the output slot is free, then commit once.
				commit = !out_valid_q || out_ready;
				if (commit) begin
					state_d     = sslt_pkg::ST_IDLE;
					out_valid_d = 1'b1;
					success_d   = 1'b0;
					status_d    = sslt_pkg::STATUS_DONE;
					unique case (op_q)
						sslt_pkg::OP_ADD: begin
							if (found) begin
								status_d = sslt_pkg::STATUS_PRESENT;
							end else if (full) begin
								status_d = sslt_pkg::STATUS_FULL;
							end else begin
								ctrl.cmd  = sslt_pkg::CMD_INSERT;
								count_d   = count_q + CNT_W'(1);
								success_d = 1'b1;
							end
						end
						sslt_pkg::OP_REMOVE: begin
							if (found) begin
								ctrl.cmd  = sslt_pkg::CMD_REMOVE;
								count_d   = count_q - CNT_W'(1);
								success_d = 1'b1;
							end else begin
								status_d = sslt_pkg::STATUS_ABSENT;
							end
						end
						default: begin
							// search, and the undefined code behaves the same
							if (found) begin
								success_d = 1'b1;
							end else begin
								status_d = sslt_pkg::STATUS_ABSENT;
							end
						end
					endcase
				end
			end
			default: state_d = sslt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			cyc_q       <= '0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_data;
			end
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
			if (state_q == sslt_pkg::ST_SCAN) begin
				cyc_q <= cyc_q + IDX_W'(1);
			end else begin
				cyc_q <= '0;
			end
		end
	end

	// Capture the transfer; the key stays broadcast to every cell for the whole item.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= opcode;
			key_q <= key;
		end
		success_q <= success_d;
		status_q  <= status_d;
	end

	assign out_valid = out_valid_q;
	assign success   = success_q;
	assign status    = status_q;
	assign count     = OUT_W'(count_q);

	// Valid cells always match the count when idle.
	a_count_matches_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sslt_pkg::ST_IDLE) |-> ($countones(cv) == int'(count_q)))
		else $error("valid cells disagree with key count");

	// Count never passes capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("key count above capacity");

	// A successful result always reports done.
	a_success_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && success_q) |-> (status_q == sslt_pkg::STATUS_DONE))
		else $error("success with non-done status");

	// Every input transfer starts a scan.
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == sslt_pkg::ST_SCAN))
		else $error("transfer did not start a scan");

endmodule
`default_nettype wire

### tb/sorted_set_linked_table_top_tb.sv
`timescale 1ns / 100ps
module sorted_set_linked_table_top_tb;

	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 32;
	localparam int COUNT_BITS = sslt_pkg::COUNT_BITS;
	// Opcode 3 has no name in the package; the block treats it as a search.
	localparam logic [1:0] OP_UNDEFINED = 2'd3;
	// Room for capture, the ripple down the row and the commit, plus slack.
	localparam int SETTLE_CYCLES = CAPACITY + 6;
	localparam int LIMIT_CYCLES = 200000;
	localparam int LONG_HOLD_CYCLES = 300;

	typedef struct {
		logic [1:0]                 op;
		logic signed [KEY_BITS-1:0] k;
	} request_t;

	typedef struct {
		logic                  success;
		sslt_pkg::status_t     status;
		logic [COUNT_BITS-1:0] count;
	} outcome_t;

	typedef enum {PH_FILL, PH_DRAIN, PH_CHURN} phase_kind_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic                       cfg_data = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [1:0]                 opcode = 2'd0;
	logic signed [KEY_BITS-1:0] key = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic                       success;
	logic [1:0]                 status;
	logic [COUNT_BITS-1:0]      count;

	// Queued requests, outcomes still owed by the block, and the shadow table:
	// held keys in list order, exactly as the block links them.
	request_t                   requests_todo[$];
	outcome_t                   outcomes_due[$];
	logic signed [KEY_BITS-1:0] held_keys[$];
	logic                       order_shadow = 1'b0;

	int offered = 0;
	int accepted = 0;
	int mismatches = 0;
	int cycles = 0;

	sorted_set_linked_table_top #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.success(success),
		.status(status),
		.count(count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Ordering relation: may key a stand ahead of key b in the list?
	function automatic logic ranks_ahead(logic signed [KEY_BITS-1:0] a,
			logic signed [KEY_BITS-1:0] b);
		return order_shadow ? (a >= b) : (a <= b);
	endfunction

	// Apply one request to the shadow table and return the outcome it owes.
	function automatic outcome_t apply_to_table(logic [1:0] op,
			logic signed [KEY_BITS-1:0] k);
		outcome_t res;
		int       hit;
		int       at;
		hit = -1;
		for (int i = held_keys.size() - 1; i >= 0; i--)
			if (held_keys[i] == k)
				hit = i;
		res.success = 1'b0;
		res.status = sslt_pkg::STATUS_DONE;
		case (op)
			sslt_pkg::OP_ADD: begin
				if (hit >= 0) begin
					res.status = sslt_pkg::STATUS_PRESENT;
				end else if (held_keys.size() >= CAPACITY) begin
					res.status = sslt_pkg::STATUS_FULL;
				end else begin
					// Walk while the held key still ranks ahead; after an order
					// switch this stops at the first key that breaks the new order.
					at = 0;
					while (at < held_keys.size() && ranks_ahead(held_keys[at], k))
						at++;
					held_keys.insert(at, k);
					res.success = 1'b1;
				end
			end
			sslt_pkg::OP_REMOVE: begin
				if (hit >= 0) begin
					held_keys.delete(hit);
					res.success = 1'b1;
				end else begin
					res.status = sslt_pkg::STATUS_ABSENT;
				end
			end
			default: begin
				// Search, and the undefined opcode acting as one.
				if (hit >= 0)
					res.success = 1'b1;
				else
					res.status = sslt_pkg::STATUS_ABSENT;
			end
		endcase
		res.count = COUNT_BITS'(held_keys.size());
		return res;
	endfunction

	task automatic report(input string what, input int got_v, input int want_v);
		$display("%0t ns: %s mismatch: got %0d, expected %0d (after %0d inputs)",
			$time, what, got_v, want_v, accepted);
		mismatches++;
	endtask

	// Result side: check each output transfer against the oldest owed outcome,
	// then predict for an input transfer taken at this same edge.
	always @(posedge clk) begin : watch_ports
		outcome_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (outcomes_due.size() == 0) begin
					report("unexpected result", {30'd0, status}, -1);
				end else begin
					want = outcomes_due.pop_front();
					if (success !== want.success)
						report("success", success, want.success);
					if (status !== want.status)
						report("status", status, want.status);
					if (count !== want.count)
						report("count", count, want.count);
				end
			end
			if (in_valid && in_ready) begin
				outcomes_due.push_back(apply_to_table(opcode, key));
				accepted++;
			end
		end
	end

	// Watchdog: end the run if the block wedges.
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Request side: offer requests in bursts separated by random gaps. Hold the
	// payload steady until the transfer, then advance to the next request.
	always @(negedge clk) begin : drive_requests
		static int burst_left = 0;
		static int gap_left = 0;
		logic     next_valid;
		request_t req;
		next_valid = in_valid;
		if (arst_n) begin
			if (in_valid && offered != accepted) begin
				next_valid = 1'b1;
			end else if (gap_left > 0) begin
				next_valid = 1'b0;
				gap_left--;
			end else if (requests_todo.size() > 0) begin
				req = requests_todo.pop_front();
				opcode <= req.op;
				key <= req.k;
				next_valid = 1'b1;
				offered++;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					// Some bursts run back to back with no gap at all.
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
				end else begin
					burst_left--;
				end
			end else begin
				next_valid = 1'b0;
			end
			in_valid <= next_valid;
		end
	end

	// Result acceptance: switch among always-ready, a rotating stall pattern and
	// random draws that are ready three times in four. Once, hold off for a long stretch so the block backs up.
	always @(negedge clk) begin : drive_ready
		static int       hold_left = 0;
		static bit       hold_done = 1'b0;
		static int       mode_left = 0;
		static int       ready_mode = 0;
		static bit [7:0] ready_pattern = 8'hff;
		logic            next_ready;
		next_ready = out_ready;
		if (arst_n) begin
			if (hold_left > 0) begin
				next_ready = 1'b0;
				hold_left--;
			end else if (!hold_done && accepted >= 60) begin
				hold_left = LONG_HOLD_CYCLES;
				hold_done = 1'b1;
				next_ready = 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 120);
					ready_pattern = 8'($urandom) | 8'h01;
				end
				mode_left--;
				case (ready_mode)
					0: next_ready = 1'b1;
					1: begin
						next_ready = ready_pattern[0];
						ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
					end
					default: next_ready = ($urandom_range(0, 3) != 0);
				endcase
			end
			out_ready <= next_ready;
		end
	end

	task automatic push_request(input logic [1:0] op, input logic signed [KEY_BITS-1:0] k);
		request_t req;
		req.op = op;
		req.k = k;
		requests_todo.push_back(req);
	endtask

	// Drain everything in flight, then let the block settle.
	task automatic wait_idle();
		@(negedge clk);
		while (requests_todo.size() != 0 || offered != accepted || outcomes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the order register; only called while the block is idle.
	task automatic set_order(input logic descending);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= descending;
		@(negedge clk);
		cfg_we <= 1'b0;
		order_shadow = descending;
	endtask

	function automatic logic [1:0] churn_opcode();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return sslt_pkg::OP_ADD;
		else if (r < 7)
			return sslt_pkg::OP_REMOVE;
		else if (r < 9)
			return sslt_pkg::OP_SEARCH;
		return OP_UNDEFINED;
	endfunction

	initial begin : stimulus
		logic signed [KEY_BITS-1:0] key_pool[12];
		logic signed [KEY_BITS-1:0] victims[$];
		logic signed [KEY_BITS-1:0] swap_key;
		logic                       phase_order[10];
		phase_kind_t                phase_kinds[10];
		int                         j;

		phase_order = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		phase_kinds = '{PH_FILL, PH_DRAIN, PH_CHURN, PH_FILL, PH_CHURN,
			PH_DRAIN, PH_CHURN, PH_CHURN, PH_FILL, PH_DRAIN};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		set_order(1'b0);

		// Directed: empty table, extremes, duplicate, undefined opcode, unlink
		// at head, middle and tail, then insert in the middle and at the tail.
		push_request(sslt_pkg::OP_SEARCH, 32'sd5);
		push_request(sslt_pkg::OP_REMOVE, 32'sd5);
		push_request(sslt_pkg::OP_ADD, 32'sd0);
		push_request(sslt_pkg::OP_ADD, 32'sh7fff_ffff);
		push_request(sslt_pkg::OP_ADD, 32'sh8000_0000);
		push_request(sslt_pkg::OP_ADD, -32'sd1);
		push_request(sslt_pkg::OP_ADD, 32'sd0);
		push_request(sslt_pkg::OP_SEARCH, 32'sh8000_0000);
		push_request(OP_UNDEFINED, 32'sh7fff_ffff);
		push_request(OP_UNDEFINED, 32'sd7);
		push_request(sslt_pkg::OP_REMOVE, -32'sd1);
		push_request(sslt_pkg::OP_REMOVE, 32'sh7fff_ffff);
		push_request(sslt_pkg::OP_REMOVE, 32'sh8000_0000);
		push_request(sslt_pkg::OP_REMOVE, 32'sh8000_0000);
		push_request(sslt_pkg::OP_ADD, 32'sd100);
		push_request(sslt_pkg::OP_ADD, 32'sd50);
		push_request(sslt_pkg::OP_ADD, 32'sd200);
		push_request(sslt_pkg::OP_ADD, 32'sd150);
		push_request(sslt_pkg::OP_SEARCH, 32'sd150);
		wait_idle();

		// Random phases. The first flips to descending with keys still held,
		// so new keys land against an ascending list.
		for (int p = 0; p < 10; p++) begin
			set_order(phase_order[p]);
			case (phase_kinds[p])
				PH_FILL: begin
					// Enough fresh adds to overflow any starting count.
					for (int i = 0; i < 24; i++)
						push_request(sslt_pkg::OP_ADD, KEY_BITS'($urandom));
				end
				PH_DRAIN: begin
					victims = held_keys;
					for (int i = victims.size() - 1; i > 0; i--) begin
						j = $urandom_range(0, i);
						swap_key = victims[i];
						victims[i] = victims[j];
						victims[j] = swap_key;
					end
					foreach (victims[i]) begin
						if ($urandom_range(0, 3) == 0)
							push_request(($urandom_range(0, 1) == 0) ? sslt_pkg::OP_REMOVE
								: OP_UNDEFINED, KEY_BITS'($urandom));
						push_request(sslt_pkg::OP_REMOVE, victims[i]);
					end
					push_request(sslt_pkg::OP_SEARCH,
						victims.size() > 0 ? victims[0] : 32'sd0);
				end
				default: begin
					// Small pool so adds, removes and searches keep colliding.
					key_pool[0] = 32'sh8000_0000;
					key_pool[1] = 32'sh7fff_ffff;
					key_pool[2] = -32'sd1;
					key_pool[3] = 32'sd0;
					key_pool[4] = 32'sd1;
					for (int i = 5; i < 12; i++)
						key_pool[i] = ($urandom_range(0, 1) == 0)
							? KEY_BITS'($urandom) : KEY_BITS'($urandom_range(0, 40)) - 20;
					for (int i = 0; i < 60; i++)
						push_request(churn_opcode(), ($urandom_range(0, 9) < 7)
							? key_pool[$urandom_range(0, 11)] : KEY_BITS'($urandom));
				end
			endcase
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
